// File: design/image_header_dimension_probe_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the image header dimension probe.
// The enclosing module must provide clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef IMAGE_HEADER_DIMENSION_PROBE_UNIT_ASSERT_SVH
`define IMAGE_HEADER_DIMENSION_PROBE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHDP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IHDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ihdp_pkg.sv
// ---------------------------------------------------------------------------
// ihdp_pkg
// Types, constants and small lookup functions shared by the image header
// dimension probe modules.
// ---------------------------------------------------------------------------
package ihdp_pkg;

  // Width of the saturating byte position counter.
  localparam int POSITION_BITS   = 22;
  localparam int SCAN_LIMIT_BITS = 22;
  localparam int CMP_BITS        = (POSITION_BITS > SCAN_LIMIT_BITS) ?
                                   POSITION_BITS + 1 : SCAN_LIMIT_BITS + 1;

  localparam logic [POSITION_BITS-1:0]   POS_MAX          = '1;
  localparam int                         HEADER_BYTES     = 26;
  localparam logic [SCAN_LIMIT_BITS-1:0] SCAN_LIMIT_RESET = SCAN_LIMIT_BITS'(128 * 1024);

  // Byte codes of interest.
  localparam logic [7:0] PNG_LEAD    = 8'h89;
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOS    = 8'hDA;
  localparam logic [7:0] MARK_RST0   = 8'hD0;
  localparam logic [7:0] MARK_RST7   = 8'hD7;
  localparam logic [7:0] MARK_TEM    = 8'h01;
  localparam logic [7:0] MARK_SOF0   = 8'hC0;
  localparam logic [7:0] MARK_SOF15  = 8'hCF;
  localparam logic [7:0] MARK_SOF2   = 8'hC2;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_JPG    = 8'hC8;
  localparam logic [7:0] MARK_DAC    = 8'hCC;

  // Result kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PNG  = 2'd1;
  localparam logic [1:0] KIND_JPEG = 2'd2;

  // Parse phases.
  typedef enum logic [3:0] {
    PH_FIRST     = 4'd0,
    PH_PNG       = 4'd1,
    PH_SOI       = 4'd2,
    PH_MARK0     = 4'd3,
    PH_MARK1     = 4'd4,
    PH_LEN0      = 4'd5,
    PH_LEN1      = 4'd6,
    PH_SKIP      = 4'd7,
    PH_SOF       = 4'd8,
    PH_HOLD_PNG  = 4'd9,
    PH_HOLD_JPEG = 4'd10,
    PH_DONE      = 4'd11
  } phase_t;

  // One input byte held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_entry;
  } item_t;

  // One result.
  typedef struct packed {
    logic [1:0]  image_kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        is_progressive;
  } result_t;

  // Expected PNG signature and IHDR tag over the first sixteen bytes.
  function automatic logic [7:0] png_magic(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h89;
      4'd1:    val = 8'h50;
      4'd2:    val = 8'h4E;
      4'd3:    val = 8'h47;
      4'd4:    val = 8'h0D;
      4'd5:    val = 8'h0A;
      4'd6:    val = 8'h1A;
      4'd7:    val = 8'h0A;
      4'd12:   val = 8'h49;
      4'd13:   val = 8'h48;
      4'd14:   val = 8'h44;
      4'd15:   val = 8'h52;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Start-of-frame markers carry the image size.
  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m >= MARK_SOF0) && (m <= MARK_SOF15) &&
           (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
  endfunction

endpackage

// File: design/ihdp_if.sv
// ---------------------------------------------------------------------------
// ihdp_in_if / ihdp_out_if
// Valid/ready channels for the byte stream and for the results.
// ---------------------------------------------------------------------------
interface ihdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_entry;

  modport source (output valid, output data_byte, output end_of_entry, input ready);
  modport sink   (input valid, input data_byte, input end_of_entry, output ready);
endinterface

interface ihdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  image_kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        is_progressive;

  modport source (output valid, output image_kind, output image_width,
                  output image_height, output is_progressive, input ready);
  modport sink   (input valid, input image_kind, input image_width,
                  input image_height, input is_progressive, output ready);
endinterface

// File: design/image_header_dimension_probe_unit.sv
// ---------------------------------------------------------------------------
// image_header_dimension_probe_unit
// Recognizes PNG and JPEG file entries from their bytes and reports the
// image kind, pixel width and height, and the progressive flag.
// ---------------------------------------------------------------------------
// Usage:
// - in_chan carries one byte per transaction, with end_of_entry set on the
//   last byte of an entry. Entries are sent back to back with no gap.
// - out_chan carries at most one result per entry: on the byte that decides
//   it, or on the last byte of the entry. Bytes after the decision are
//   consumed without a result.
// - cfg_wr_en/cfg_wr_data write scan_limit; write it only while idle.
// - Throughput is one byte per cycle while the result register is free. A
//   byte is parsed as it leaves the input register, and that step also
//   loads its result into the result register: the input register and
//   the result register lie around a single parse step.
// - When the receiver stalls, the result register holds its result and the
//   input register holds one more byte; in_chan.ready then drops.
// - Reset clears the parser to the start of an entry, empties both
//   registers and sets scan_limit to 131072.
// ---------------------------------------------------------------------------
module image_header_dimension_probe_unit
  import ihdp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  ihdp_in_if.sink                    in_chan,
  ihdp_out_if.source                 out_chan,
  input  logic                       cfg_wr_en,
  input  logic [SCAN_LIMIT_BITS-1:0] cfg_wr_data
);

  `include "image_header_dimension_probe_unit_assert.svh"

  logic                       item_valid, adv, emit, out_free;
  item_t                      item;
  result_t                    result;
  logic [SCAN_LIMIT_BITS-1:0] scan_limit_r;

  // Scan limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= SCAN_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      scan_limit_r <= cfg_wr_data;
    end
  end

  // A byte moves into the parser when the result register can take a result.
  assign adv = item_valid && out_free;

  ihdp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item),
    .in_chan    (in_chan)
  );

  ihdp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item       (item),
    .scan_limit (scan_limit_r),
    .emit       (emit),
    .result     (result)
  );

  ihdp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv && emit),
    .result   (result),
    .free     (out_free),
    .out_chan (out_chan)
  );

  // A none result carries no size and no flag.
  `IHDP_ASSERT_NOW(a_none_is_zero, out_chan.valid && (out_chan.image_kind == KIND_NONE), (out_chan.image_width == 16'd0) && (out_chan.image_height == 16'd0) && !out_chan.is_progressive, "none result with nonzero fields")
  // Only JPEG results can be progressive.
  `IHDP_ASSERT_NOW(a_prog_is_jpeg, out_chan.valid && out_chan.is_progressive, out_chan.image_kind == KIND_JPEG, "progressive flag on a non-JPEG result")
  // A PNG result always has a nonzero size.
  `IHDP_ASSERT_NOW(a_png_size, out_chan.valid && (out_chan.image_kind == KIND_PNG), (out_chan.image_width != 16'd0) && (out_chan.image_height != 16'd0), "PNG result with zero size")

endmodule

// File: design/ihdp_in_reg.sv
// ---------------------------------------------------------------------------
// ihdp_in_reg
// Input register: captures one byte per transaction and holds it until the
// parser consumes it.
// ---------------------------------------------------------------------------
module ihdp_in_reg
  import ihdp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  output logic  item_valid,
  output item_t item,
  ihdp_in_if.sink in_chan
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  in_fire;

  // The register is free when empty or when its byte moves on this cycle.
  assign in_chan.ready = !valid_r || adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.data_byte    <= in_chan.data_byte;
      item_r.end_of_entry <= in_chan.end_of_entry;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: design/ihdp_parser.sv
// ---------------------------------------------------------------------------
// ihdp_parser
// Per-byte header parser: recognizes PNG and JPEG, walks JPEG segments and
// decides the result of an entry.
// ---------------------------------------------------------------------------
module ihdp_parser
  import ihdp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  item_t                      item,
  input  logic [SCAN_LIMIT_BITS-1:0] scan_limit,
  output logic                       emit,
  output result_t                    result
);

  `include "image_header_dimension_probe_unit_assert.svh"

  phase_t                   phase_r, phase_nxt, phase_step;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_inc, consumed;
  logic                     sig_ok_r, sig_ok_nxt, sig_step;
  logic [31:0]              width_r, width_nxt, width_step;
  logic [31:0]              height_r, height_nxt, height_step;
  logic [7:0]               marker_r, marker_nxt, marker_step;
  logic [15:0]              skip_r, skip_nxt, skip_step;
  logic [2:0]               field_r, field_nxt, field_step;
  logic                     sent_r, sent_nxt;

  logic [7:0]  data_b;
  logic        last;
  logic        none_now, hold_emit, hdr_reached, limit_hit;
  logic        magic_chk, png_ok, standalone, end_marker, len_short;
  logic [15:0] seg_len;

  assign data_b = item.data_byte;
  assign last   = item.end_of_entry;

  // Position bookkeeping.
  assign pos_inc     = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign hdr_reached = pos_inc >= POSITION_BITS'(HEADER_BYTES);
  assign consumed    = (pos_r < POSITION_BITS'(HEADER_BYTES)) ?
                       POSITION_BITS'(HEADER_BYTES) : pos_r;
  assign limit_hit   = CMP_BITS'(consumed) >= CMP_BITS'(scan_limit);

  // Byte classification.
  assign magic_chk  = (pos_r < POSITION_BITS'(16)) &&
                      ((pos_r < POSITION_BITS'(8)) || (pos_r >= POSITION_BITS'(12)));
  assign standalone = (data_b == MARK_SOI) || (data_b == MARK_TEM) ||
                      ((data_b >= MARK_RST0) && (data_b <= MARK_RST7));
  assign end_marker = (data_b == MARK_EOI) || (data_b == MARK_SOS);
  assign seg_len    = {skip_r[15:8], data_b};
  assign len_short  = seg_len < 16'd2;

  // Field updates caused by this byte, before the end-of-entry clear.
  always_comb begin
    sig_step    = sig_ok_r;
    width_step  = width_r;
    height_step = height_r;
    marker_step = marker_r;
    skip_step   = skip_r;
    field_step  = field_r;
    case (phase_r)
      PH_PNG: begin
        if (magic_chk && (data_b != png_magic(pos_r[3:0]))) begin
          sig_step = 1'b0;
        end
        if ((pos_r >= POSITION_BITS'(16)) && (pos_r < POSITION_BITS'(20))) begin
          width_step = {width_r[23:0], data_b};
        end else if (pos_r >= POSITION_BITS'(20)) begin
          height_step = {height_r[23:0], data_b};
        end
      end
      PH_MARK1: begin
        if (!standalone && !end_marker) begin
          marker_step = data_b;
        end
      end
      PH_LEN0: begin
        skip_step = {data_b, 8'h00};
      end
      PH_LEN1: begin
        if (!len_short) begin
          if (is_frame_marker(marker_r)) begin
            field_step = 3'd0;
          end else begin
            skip_step = seg_len - 16'd2;
          end
        end
      end
      PH_SKIP: begin
        skip_step = skip_r - 16'd1;
      end
      PH_SOF: begin
        case (field_r)
          3'd1:    height_step = {16'h0000, data_b, 8'h00};
          3'd2:    height_step = height_r | {24'h000000, data_b};
          3'd3:    width_step  = {16'h0000, data_b, 8'h00};
          3'd4:    width_step  = width_r | {24'h000000, data_b};
          default: ;
        endcase
        field_step = field_r + 3'd1;
      end
      default: ;
    endcase
  end

  assign png_ok = sig_step &&
                  (width_step != 32'd0) && (width_step[31:16] == 16'h0000) &&
                  (height_step != 32'd0) && (height_step[31:16] == 16'h0000);

  // Decision: a byte that rules the entry out.
  always_comb begin
    unique case (phase_r)
      PH_FIRST: none_now = (data_b != PNG_LEAD) && (data_b != MARK_PREFIX);
      PH_PNG:   none_now = (pos_r >= POSITION_BITS'(23)) && !png_ok;
      PH_SOI:   none_now = data_b != MARK_SOI;
      PH_MARK0: none_now = limit_hit || (data_b != MARK_PREFIX);
      PH_MARK1: none_now = end_marker;
      PH_LEN1:  none_now = len_short;
      default:  none_now = 1'b0;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_step = phase_r;
    unique case (phase_r)
      PH_FIRST: begin
        if (data_b == PNG_LEAD) begin
          phase_step = PH_PNG;
        end else if (data_b == MARK_PREFIX) begin
          phase_step = PH_SOI;
        end
      end
      PH_PNG: begin
        if ((pos_r >= POSITION_BITS'(23)) && png_ok) begin
          phase_step = PH_HOLD_PNG;
        end
      end
      PH_SOI: begin
        if (data_b == MARK_SOI) begin
          phase_step = PH_MARK0;
        end
      end
      PH_MARK0: begin
        phase_step = PH_MARK1;
      end
      PH_MARK1: begin
        phase_step = standalone ? PH_MARK0 : PH_LEN0;
      end
      PH_LEN0: begin
        phase_step = PH_LEN1;
      end
      PH_LEN1: begin
        if (is_frame_marker(marker_r)) begin
          phase_step = PH_SOF;
        end else if (skip_step == 16'd0) begin
          phase_step = PH_MARK0;
        end else begin
          phase_step = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_step == 16'd0) begin
          phase_step = PH_MARK0;
        end
      end
      PH_SOF: begin
        if (field_r >= 3'd4) begin
          phase_step = PH_HOLD_JPEG;
        end
      end
      default: ;
    endcase

    if (last) begin
      phase_nxt = PH_FIRST;
    end else if (none_now || hold_emit) begin
      phase_nxt = PH_DONE;
    end else begin
      phase_nxt = phase_step;
    end
  end

  // Result selection and the end-of-entry clear.
  assign hold_emit = !none_now && hdr_reached &&
                     ((phase_step == PH_HOLD_PNG) || (phase_step == PH_HOLD_JPEG));
  assign emit      = none_now || hold_emit || (last && !sent_r);

  always_comb begin
    result = '0;
    if (hold_emit) begin
      result.image_width  = width_step[15:0];
      result.image_height = height_step[15:0];
      if (phase_step == PH_HOLD_PNG) begin
        result.image_kind = KIND_PNG;
      end else begin
        result.image_kind     = KIND_JPEG;
        result.is_progressive = marker_r == MARK_SOF2;
      end
    end
  end

  always_comb begin
    if (last) begin
      pos_nxt    = '0;
      sig_ok_nxt = 1'b1;
      width_nxt  = 32'd0;
      height_nxt = 32'd0;
      marker_nxt = 8'h00;
      skip_nxt   = 16'd0;
      field_nxt  = 3'd0;
      sent_nxt   = 1'b0;
    end else begin
      pos_nxt    = pos_inc;
      sig_ok_nxt = sig_step;
      width_nxt  = width_step;
      height_nxt = height_step;
      marker_nxt = marker_step;
      skip_nxt   = skip_step;
      field_nxt  = field_step;
      sent_nxt   = sent_r || none_now || hold_emit;
    end
  end

  // Parser state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      pos_r    <= '0;
      sig_ok_r <= 1'b1;
      width_r  <= 32'd0;
      height_r <= 32'd0;
      marker_r <= 8'h00;
      skip_r   <= 16'd0;
      field_r  <= 3'd0;
      sent_r   <= 1'b0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      sig_ok_r <= sig_ok_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      marker_r <= marker_nxt;
      skip_r   <= skip_nxt;
      field_r  <= field_nxt;
      sent_r   <= sent_nxt;
    end
  end

  // An entry boundary returns the parser to its initial state.
  `IHDP_ASSERT_NEXT(a_entry_clear, adv && last, (phase_r == PH_FIRST) && (pos_r == '0) && !sent_r, "parser state not cleared after the last byte")
  // Only one result per entry.
  `IHDP_ASSERT_NOW(a_single_result, adv && emit, !sent_r, "second result within one entry")
  // Once decided, the parser rests in the done phase until the entry ends.
  `IHDP_ASSERT_NEXT(a_done_after_emit, adv && emit && !last, (phase_r == PH_DONE) && sent_r, "parser not done after its result")

endmodule

// File: design/ihdp_out_reg.sv
// ---------------------------------------------------------------------------
// ihdp_out_reg
// Result register: holds one result until the receiver takes it.
// ---------------------------------------------------------------------------
module ihdp_out_reg
  import ihdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    free,
  ihdp_out_if.source out_chan
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  // Free when empty or when the held result leaves this cycle.
  assign free = !valid_r || out_chan.ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.image_kind     = result_r.image_kind;
  assign out_chan.image_width    = result_r.image_width;
  assign out_chan.image_height   = result_r.image_height;
  assign out_chan.is_progressive = result_r.is_progressive;

endmodule
